@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers shared by the downsampler RTL. The bodies
// drop out when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define BDS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("bds assertion failed");
// Condition must never be true outside reset.
`define BDS_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("bds forbidden condition seen");
`else
`define BDS_ASSERT(lbl, clk, rst_n, prop)
`define BDS_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

@@ sv/bds_pkg.sv @@
// ----------------------------------------------------------------------------
// bds_pkg
// Shared constants, types and helpers of the 2x2 box downsampler.
// ----------------------------------------------------------------------------
package bds_pkg;

  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;
  localparam int LINE_DEPTH = MAX_WIDTH / 2;
  localparam int SLOT_W     = $clog2(LINE_DEPTH);
  localparam int POS_W      = $clog2(MAX_WIDTH > MAX_HEIGHT ? MAX_WIDTH : MAX_HEIGHT);
  localparam int DIM_W      = 13;
  localparam int CNT_W      = 3;
  localparam int LANES      = 4;
  localparam int PIX_W      = 8;
  localparam int SUM_W      = PIX_W + 1;
  localparam int LINE_W     = LANES * SUM_W;
  localparam int CFG_IDX_W  = 2;

  localparam logic [DIM_W-1:0] WIDTH_RST  = DIM_W'(64);
  localparam logic [DIM_W-1:0] HEIGHT_RST = DIM_W'(64);
  localparam logic [CNT_W-1:0] CHANS_RST  = CNT_W'(4);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_CHANS  = 2'd2
  } cfg_idx_t;

  // Per-pixel control fanned out from the position tracker to every lane.
  typedef struct packed {
    logic accept;    // pixel transaction taken this cycle
    logic col_even;  // first pixel of a horizontal pair
  } lane_ctl_t;

  // Round down to even, clamp to [2, maxv].
  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v,
                                               input logic [DIM_W-1:0] maxv);
    logic [DIM_W-1:0] e;
    e = {v[DIM_W-1:1], 1'b0};
    if (e < DIM_W'(2)) e = DIM_W'(2);
    if (e > maxv) e = maxv;
    return e;
  endfunction

  // Map 0 to 1 and 5..7 to 4.
  function automatic logic [CNT_W-1:0] eff_chans(input logic [CNT_W-1:0] v);
    logic [CNT_W-1:0] e;
    e = v;
    if (v == CNT_W'(0)) e = CNT_W'(1);
    if (v > CNT_W'(LANES)) e = CNT_W'(LANES);
    return e;
  endfunction

endpackage

@@ sv/bds_line_ram.sv @@
// ----------------------------------------------------------------------------
// bds_line_ram
// Line buffer of horizontal pair sums, one write and one read port,
// registered read data.
// ----------------------------------------------------------------------------
module bds_line_ram (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [bds_pkg::SLOT_W-1:0]  wr_addr,
  input  logic [bds_pkg::LINE_W-1:0]  wr_data,
  input  logic                        rd_en,
  input  logic [bds_pkg::SLOT_W-1:0]  rd_addr,
  output logic [bds_pkg::LINE_W-1:0]  rd_data
);

  logic [bds_pkg::LINE_W-1:0] mem [bds_pkg::LINE_DEPTH];
  logic [bds_pkg::LINE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Hold read data until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ sv/bds_lane.sv @@
// ----------------------------------------------------------------------------
// bds_lane
// One channel lane: horizontal pair sum and 2x2 average.
// ----------------------------------------------------------------------------
module bds_lane (
  input  logic                        clk,
  input  bds_pkg::lane_ctl_t          ctl,
  input  logic                        lane_on,
  input  logic [bds_pkg::PIX_W-1:0]   pix,
  input  logic [bds_pkg::SUM_W-1:0]   up_sum,
  output logic [bds_pkg::SUM_W-1:0]   pair_sum,
  output logic [bds_pkg::PIX_W-1:0]   avg
);

  logic [bds_pkg::PIX_W-1:0] px;
  logic [bds_pkg::SUM_W-1:0] first_r;
  logic [bds_pkg::SUM_W:0]   quad;

  // Drop channels beyond the configured count.
  assign px = lane_on ? pix : '0;

  always_ff @(posedge clk) begin
    if (ctl.accept && ctl.col_even) begin
      first_r <= {1'b0, px};
    end
  end

  assign pair_sum = first_r + {1'b0, px};
  assign quad     = {1'b0, pair_sum} + {1'b0, up_sum};
  assign avg      = lane_on ? quad[bds_pkg::SUM_W:2] : '0;

endmodule

@@ sv/box_downsample_2x2.sv @@
// ----------------------------------------------------------------------------
// box_downsample_2x2
// 2x2 box-filter downsampler for a raster-order pixel stream.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_*): one pixel transaction per cycle, four 8-bit
//   channels, raster order. A transaction is taken when in_valid is high and
//   in_stall is low.
//   Output channel (out_*): one averaged pixel per 2x2 block, taken when
//   out_valid is high and out_stall is low. out_frame_last marks the final
//   result of a frame; the next input pixel starts a new frame.
//   Config channel (cfg_*): cfg_ready is always high. Index 0 = width,
//   1 = height, 2 = channel count. Any write to a listed register restarts
//   the frame. Write only while the block is idle.
//   Result timing: out_* is registered and shows the result in the cycle
//   after the pixel at the odd row / odd column of its block is taken.
//   Throughput: one pixel per clock while in_stall is low. Four channel lanes
//   work in parallel; the line buffer has one write and one read port and
//   each pixel uses at most one of them, which sets this rate.
//   Reset: width and height 64, four channels, position at frame start.
//   The line buffer is not cleared; every entry is written on an even row
//   before the odd row reads it.
//   Stall: while a result waits with out_stall high, in_stall is raised and
//   all state holds but for config writes, which still take effect.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module box_downsample_2x2 (
  input  logic                            clk,
  input  logic                            rst_n,
  // pixel input
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [bds_pkg::PIX_W-1:0]       in_chan_a,
  input  logic [bds_pkg::PIX_W-1:0]       in_chan_b,
  input  logic [bds_pkg::PIX_W-1:0]       in_chan_c,
  input  logic [bds_pkg::PIX_W-1:0]       in_chan_d,
  // averaged output
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [bds_pkg::PIX_W-1:0]       out_avg_a,
  output logic [bds_pkg::PIX_W-1:0]       out_avg_b,
  output logic [bds_pkg::PIX_W-1:0]       out_avg_c,
  output logic [bds_pkg::PIX_W-1:0]       out_avg_d,
  output logic                            out_frame_last,
  // configuration writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bds_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bds_pkg::DIM_W-1:0]       cfg_data
);

  localparam int LANES = bds_pkg::LANES;

  // Effective (already clamped) configuration.
  logic [bds_pkg::DIM_W-1:0] width_r,  width_nxt;
  logic [bds_pkg::DIM_W-1:0] height_r, height_nxt;
  logic [bds_pkg::CNT_W-1:0] chans_r,  chans_nxt;
  logic                      cfg_hit;

  // Position tracking.
  logic [bds_pkg::POS_W-1:0] col_r, col_nxt;
  logic [bds_pkg::POS_W-1:0] row_r, row_nxt;
  logic                      col_last, row_last;

  logic                      in_acc;
  logic                      emit;
  logic                      ram_we, ram_re;
  logic [bds_pkg::SLOT_W-1:0] slot;
  logic [bds_pkg::LINE_W-1:0] ram_wdata, ram_rdata;

  bds_pkg::lane_ctl_t        ctl;
  logic [LANES-1:0]          lane_on;
  logic [bds_pkg::PIX_W-1:0] pix      [LANES];
  logic [bds_pkg::PIX_W-1:0] lane_avg [LANES];

  // Output register.
  logic                      out_valid_r, out_valid_nxt;
  logic [bds_pkg::PIX_W-1:0] avg_r [LANES];
  logic                      last_r;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid_r && out_stall;
  assign in_acc    = in_valid && !in_stall;

  // ---------------- configuration ----------------
  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    chans_nxt  = chans_r;
    cfg_hit    = 1'b0;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bds_pkg::CFG_WIDTH: begin
          width_nxt = bds_pkg::eff_dim(cfg_data, bds_pkg::DIM_W'(bds_pkg::MAX_WIDTH));
          cfg_hit   = 1'b1;
        end
        bds_pkg::CFG_HEIGHT: begin
          height_nxt = bds_pkg::eff_dim(cfg_data, bds_pkg::DIM_W'(bds_pkg::MAX_HEIGHT));
          cfg_hit    = 1'b1;
        end
        bds_pkg::CFG_CHANS: begin
          chans_nxt = bds_pkg::eff_chans(cfg_data[bds_pkg::CNT_W-1:0]);
          cfg_hit   = 1'b1;
        end
        default: begin
          cfg_hit = 1'b0;
        end
      endcase
    end
  end

  // ---------------- raster position ----------------
  assign col_last = ({1'b0, col_r} == width_r  - bds_pkg::DIM_W'(1));
  assign row_last = ({1'b0, row_r} == height_r - bds_pkg::DIM_W'(1));

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (cfg_hit) begin
      // restart the frame
      col_nxt = '0;
      row_nxt = '0;
    end else if (in_acc) begin
      if (col_last) begin
        col_nxt = '0;
        row_nxt = row_last ? '0 : row_r + bds_pkg::POS_W'(1);
      end else begin
        col_nxt = col_r + bds_pkg::POS_W'(1);
      end
    end
  end

  // Even rows write pair sums at the odd column; odd rows fetch the stored
  // sum at the even column so it is ready when the pair completes.
  assign slot   = col_r[bds_pkg::POS_W-1:1];
  assign ram_we = in_acc &&  col_r[0] && !row_r[0];
  assign ram_re = in_acc && !col_r[0] &&  row_r[0];
  assign emit   = in_acc &&  col_r[0] &&  row_r[0];

  bds_line_ram u_line_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (slot),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (slot),
    .rd_data (ram_rdata)
  );

  // ---------------- channel lanes ----------------
  assign ctl.accept   = in_acc;
  assign ctl.col_even = !col_r[0];

  assign pix[0] = in_chan_a;
  assign pix[1] = in_chan_b;
  assign pix[2] = in_chan_c;
  assign pix[3] = in_chan_d;

  for (genvar k = 0; k < LANES; k++) begin : g_lane
    assign lane_on[k] = (chans_r > bds_pkg::CNT_W'(k));

    bds_lane u_lane (
      .clk      (clk),
      .ctl      (ctl),
      .lane_on  (lane_on[k]),
      .pix      (pix[k]),
      .up_sum   (ram_rdata[k*bds_pkg::SUM_W +: bds_pkg::SUM_W]),
      .pair_sum (ram_wdata[k*bds_pkg::SUM_W +: bds_pkg::SUM_W]),
      .avg      (lane_avg[k])
    );
  end

  // ---------------- merge into output register ----------------
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r     <= bds_pkg::WIDTH_RST;
      height_r    <= bds_pkg::HEIGHT_RST;
      chans_r     <= bds_pkg::CHANS_RST;
      col_r       <= '0;
      row_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      width_r     <= width_nxt;
      height_r    <= height_nxt;
      chans_r     <= chans_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload: load on emit only, hold otherwise.
  always_ff @(posedge clk) begin
    if (emit) begin
      for (int k = 0; k < LANES; k++) begin
        avg_r[k] <= lane_avg[k];
      end
      last_r <= row_last && col_last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_avg_a      = avg_r[0];
  assign out_avg_b      = avg_r[1];
  assign out_avg_c      = avg_r[2];
  assign out_avg_d      = avg_r[3];
  assign out_frame_last = last_r;

  // ---------------- assertions ----------------
  `BDS_NEVER(a_ram_port_clash, clk, rst_n, ram_we && ram_re)
  `BDS_ASSERT(a_col_in_range, clk, rst_n, {1'b0, col_r} < width_r)
  `BDS_ASSERT(a_row_in_range, clk, rst_n, {1'b0, row_r} < height_r)
  `BDS_ASSERT(a_emit_shows, clk, rst_n, emit |=> out_valid_r)
  `BDS_NEVER(a_emit_while_full, clk, rst_n, emit && out_valid_r && out_stall)

endmodule
